@@ design/fuzzy_gain_schedule_macros.svh @@
// Assertion macros for the fuzzy gain schedule checker.
// No dependencies; included by the checker file only.
`ifndef FUZZY_GAIN_SCHEDULE_MACROS_SVH
`define FUZZY_GAIN_SCHEDULE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define FGS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define FGS_ASSERT_NEXT(lbl, ck, ante, cons, rs, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset.
`define FGS_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/fgs_pkg.sv @@
// Shared constants, codes and pipeline payload types for the fuzzy gain schedule.
// No dependencies; used by fgs_div_pipe, fuzzy_gain_schedule and the port checker.
package fgs_pkg;

  localparam int GRADE_FRAC_BITS    = 16;
  localparam int BP_W               = 11;
  localparam int DEV_W              = BP_W + 1;
  localparam int WEIGHT_W           = 24;
  localparam int GAIN_W             = 24;
  localparam int CFG_IDX_W          = 3;
  localparam int GRADE_W            = GRADE_FRAC_BITS + 1;
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         =
      (GRADE_FRAC_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int PROD_W             = GRADE_W + WEIGHT_W;
  localparam int SUM_W              = PROD_W + 2;
  // front stage + divider stages + product stage + output stage
  localparam int PIPE_STAGES        = DIV_STAGES + 3;

  localparam logic [BP_W-1:0]     CLOSE_RESET   = 11'd0;
  localparam logic [BP_W-1:0]     MIDDLE_RESET  = 11'd100;
  localparam logic [BP_W-1:0]     DISTANT_RESET = 11'd200;
  localparam logic [WEIGHT_W-1:0] W_DIST_RESET  = 24'd167772;
  localparam logic [WEIGHT_W-1:0] W_MID_RESET   = 24'd83886;
  localparam logic [WEIGHT_W-1:0] W_CLOSE_RESET = 24'd1678;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOSE_POINT    = 3'd0,
    CFG_MIDDLE_POINT   = 3'd1,
    CFG_DISTANT_POINT  = 3'd2,
    CFG_WEIGHT_DISTANT = 3'd3,
    CFG_WEIGHT_MIDDLE  = 3'd4,
    CFG_WEIGHT_CLOSE   = 3'd5
  } cfg_index_t;

  // Where a grade comes from once the divider is done.
  typedef enum logic [1:0] {
    GRADE_ZERO,
    GRADE_ONE,
    GRADE_QA,
    GRADE_QB
  } grade_src_t;

  typedef struct packed {
    logic       order_error;
    grade_src_t src_rise;
    grade_src_t src_tri;
    grade_src_t src_fall;
  } grade_sel_t;

  // Two division lanes sharing one divisor.
  typedef struct packed {
    grade_sel_t                 sel;
    logic [BP_W-1:0]            den;
    logic [BP_W-1:0]            rem_a;
    logic [BP_W-1:0]            rem_b;
    logic [GRADE_FRAC_BITS-1:0] quo_a;
    logic [GRADE_FRAC_BITS-1:0] quo_b;
  } div_lane_t;

endpackage

@@ design/fgs_div_pipe.sv @@
// Pipelined restoring divider, two lanes over a shared divisor.
// Depends on fgs_pkg; instantiated by fuzzy_gain_schedule.
module fgs_div_pipe (
  input  logic                              clk,
  input  logic [fgs_pkg::DIV_STAGES-1:0]    en,
  input  fgs_pkg::div_lane_t                din,
  output fgs_pkg::div_lane_t                dout
);

  fgs_pkg::div_lane_t stage_q [fgs_pkg::DIV_STAGES];

  for (genvar s = 0; s < fgs_pkg::DIV_STAGES; s++) begin : g_stage
    fgs_pkg::div_lane_t cur;
    fgs_pkg::div_lane_t nxt;

    if (s == 0) begin : g_first
      assign cur = din;
    end else begin : g_rest
      assign cur = stage_q[s-1];
    end

    // Up to four quotient bits per stage; remainder always stays below den.
    always_comb begin
      logic [fgs_pkg::BP_W:0] trial_a;
      logic [fgs_pkg::BP_W:0] trial_b;
      nxt = cur;
      for (int j = 0; j < fgs_pkg::DIV_BITS_PER_STAGE; j++) begin
        if (s * fgs_pkg::DIV_BITS_PER_STAGE + j < fgs_pkg::GRADE_FRAC_BITS) begin
          trial_a = {nxt.rem_a, 1'b0};
          trial_b = {nxt.rem_b, 1'b0};
          if (trial_a >= {1'b0, nxt.den}) begin
            nxt.rem_a = fgs_pkg::BP_W'(trial_a - {1'b0, nxt.den});
            nxt.quo_a = {nxt.quo_a[fgs_pkg::GRADE_FRAC_BITS-2:0], 1'b1};
          end else begin
            nxt.rem_a = trial_a[fgs_pkg::BP_W-1:0];
            nxt.quo_a = {nxt.quo_a[fgs_pkg::GRADE_FRAC_BITS-2:0], 1'b0};
          end
          if (trial_b >= {1'b0, nxt.den}) begin
            nxt.rem_b = fgs_pkg::BP_W'(trial_b - {1'b0, nxt.den});
            nxt.quo_b = {nxt.quo_b[fgs_pkg::GRADE_FRAC_BITS-2:0], 1'b1};
          end else begin
            nxt.rem_b = trial_b[fgs_pkg::BP_W-1:0];
            nxt.quo_b = {nxt.quo_b[fgs_pkg::GRADE_FRAC_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        stage_q[s] <= nxt;
      end
    end
  end

  assign dout = stage_q[fgs_pkg::DIV_STAGES-1];

endmodule

@@ design/fuzzy_gain_schedule.sv @@
// Fuzzy gain schedule: maps a signed deviation to a Q0.24 gain from three membership
// grades (falling ramp, triangle, rising ramp) and three weights. Fully pipelined: one
// request per cycle unless stalled; the restoring divider retires four quotient bits
// per stage. Stalls ripple back stage by stage, so bubbles are squeezed out and
// in_stall rises only when every stage holds a request. Breakpoints out of order give
// order_error = 1 and gain = 0. The user must see that configuration is taken only
// while no request is in flight; the block itself does not enforce this.
module fuzzy_gain_schedule (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fgs_pkg::WEIGHT_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [fgs_pkg::DEV_W-1:0]    deviation,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fgs_pkg::GAIN_W-1:0]          gain,
  output logic                                order_error
);

  localparam int ProdStage = fgs_pkg::DIV_STAGES + 1;
  localparam int OutStage  = fgs_pkg::PIPE_STAGES - 1;
  localparam int F         = fgs_pkg::GRADE_FRAC_BITS;

  logic [fgs_pkg::BP_W-1:0]     close_point;
  logic [fgs_pkg::BP_W-1:0]     middle_point;
  logic [fgs_pkg::BP_W-1:0]     distant_point;
  logic [fgs_pkg::WEIGHT_W-1:0] weight_distant;
  logic [fgs_pkg::WEIGHT_W-1:0] weight_middle;
  logic [fgs_pkg::WEIGHT_W-1:0] weight_close;

  logic [fgs_pkg::PIPE_STAGES-1:0] valid;
  logic [fgs_pkg::PIPE_STAGES-1:0] valid_next;
  logic [fgs_pkg::PIPE_STAGES-1:0] en;

  fgs_pkg::div_lane_t front_next;
  fgs_pkg::div_lane_t front;
  fgs_pkg::div_lane_t div_out;

  logic [fgs_pkg::PROD_W-1:0] prod_rise;
  logic [fgs_pkg::PROD_W-1:0] prod_tri;
  logic [fgs_pkg::PROD_W-1:0] prod_fall;
  logic                       prod_err;

  logic [fgs_pkg::GRADE_W-1:0] grade_rise;
  logic [fgs_pkg::GRADE_W-1:0] grade_tri;
  logic [fgs_pkg::GRADE_W-1:0] grade_fall;

  logic [fgs_pkg::SUM_W-1:0]   sum;
  logic [fgs_pkg::SUM_W-F-1:0] scaled;
  logic [fgs_pkg::GAIN_W-1:0]  gain_next;

  function automatic logic [fgs_pkg::GRADE_W-1:0] pick_grade(
    fgs_pkg::grade_src_t          src,
    logic [F-1:0]                 qa,
    logic [F-1:0]                 qb
  );
    logic [fgs_pkg::GRADE_W-1:0] g;
    case (src)
      fgs_pkg::GRADE_ZERO: g = '0;
      fgs_pkg::GRADE_ONE:  g = {1'b1, {F{1'b0}}};
      fgs_pkg::GRADE_QA:   g = {1'b0, qa};
      fgs_pkg::GRADE_QB:   g = {1'b0, qb};
      default:             g = '0;
    endcase
    return g;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      close_point    <= fgs_pkg::CLOSE_RESET;
      middle_point   <= fgs_pkg::MIDDLE_RESET;
      distant_point  <= fgs_pkg::DISTANT_RESET;
      weight_distant <= fgs_pkg::W_DIST_RESET;
      weight_middle  <= fgs_pkg::W_MID_RESET;
      weight_close   <= fgs_pkg::W_CLOSE_RESET;
    end else if (cfg_write) begin
      unique case (fgs_pkg::cfg_index_t'(cfg_index))
        fgs_pkg::CFG_CLOSE_POINT:    close_point    <= cfg_data[fgs_pkg::BP_W-1:0];
        fgs_pkg::CFG_MIDDLE_POINT:   middle_point   <= cfg_data[fgs_pkg::BP_W-1:0];
        fgs_pkg::CFG_DISTANT_POINT:  distant_point  <= cfg_data[fgs_pkg::BP_W-1:0];
        fgs_pkg::CFG_WEIGHT_DISTANT: weight_distant <= cfg_data;
        fgs_pkg::CFG_WEIGHT_MIDDLE:  weight_middle  <= cfg_data;
        fgs_pkg::CFG_WEIGHT_CLOSE:   weight_close   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-stage advance: a stage loads when empty or when its successor moves.
  always_comb begin
    en[OutStage] = !valid[OutStage] || !out_stall;
    for (int i = OutStage - 1; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign in_stall   = !en[0];
  assign valid_next = {valid[fgs_pkg::PIPE_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < fgs_pkg::PIPE_STAGES; i++) begin
        if (en[i]) begin
          valid[i] <= valid_next[i];
        end
      end
    end
  end

  // Front stage: classify deviation against breakpoints, set up division.
  // Low region (close, middle): lane A = x-c (triangle), lane B = m-x (falling).
  // High region (middle, distant): lane A = x-m (rising), lane B = d-x (triangle).
  always_comb begin
    logic signed [fgs_pkg::DEV_W-1:0] cs;
    logic signed [fgs_pkg::DEV_W-1:0] ms;
    logic signed [fgs_pkg::DEV_W-1:0] ds;
    logic signed [fgs_pkg::DEV_W-1:0] x_c;
    logic signed [fgs_pkg::DEV_W-1:0] x_m;
    logic signed [fgs_pkg::DEV_W-1:0] m_x;
    logic signed [fgs_pkg::DEV_W-1:0] d_x;
    logic                             in_lo;
    logic                             in_hi;
    cs    = $signed({1'b0, close_point});
    ms    = $signed({1'b0, middle_point});
    ds    = $signed({1'b0, distant_point});
    x_c   = deviation - cs;
    x_m   = deviation - ms;
    m_x   = ms - deviation;
    d_x   = ds - deviation;
    in_lo = (deviation > cs) && (deviation < ms);
    in_hi = (deviation > ms) && (deviation < ds);

    front_next = '0;
    front_next.sel.order_error = (close_point > middle_point) ||
                                 (middle_point > distant_point);

    if (in_hi) begin
      front_next.den   = distant_point - middle_point;
      front_next.rem_a = x_m[fgs_pkg::BP_W-1:0];
      front_next.rem_b = d_x[fgs_pkg::BP_W-1:0];
    end else if (in_lo) begin
      front_next.den   = middle_point - close_point;
      front_next.rem_a = x_c[fgs_pkg::BP_W-1:0];
      front_next.rem_b = m_x[fgs_pkg::BP_W-1:0];
    end else begin
      front_next.den   = fgs_pkg::BP_W'(1);
    end

    if (deviation <= ms) begin
      front_next.sel.src_rise = fgs_pkg::GRADE_ZERO;
    end else if (deviation >= ds) begin
      front_next.sel.src_rise = fgs_pkg::GRADE_ONE;
    end else begin
      front_next.sel.src_rise = fgs_pkg::GRADE_QA;
    end

    if (deviation <= cs || deviation >= ds) begin
      front_next.sel.src_tri = fgs_pkg::GRADE_ZERO;
    end else if (deviation == ms) begin
      front_next.sel.src_tri = fgs_pkg::GRADE_ONE;
    end else if (deviation < ms) begin
      front_next.sel.src_tri = fgs_pkg::GRADE_QA;
    end else begin
      front_next.sel.src_tri = fgs_pkg::GRADE_QB;
    end

    if (deviation <= cs) begin
      front_next.sel.src_fall = fgs_pkg::GRADE_ONE;
    end else if (deviation >= ms) begin
      front_next.sel.src_fall = fgs_pkg::GRADE_ZERO;
    end else begin
      front_next.sel.src_fall = fgs_pkg::GRADE_QB;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      front <= front_next;
    end
  end

  fgs_div_pipe u_div (
    .clk  (clk),
    .en   (en[fgs_pkg::DIV_STAGES:1]),
    .din  (front),
    .dout (div_out)
  );

  // Product stage
  always_comb begin
    grade_rise = pick_grade(div_out.sel.src_rise, div_out.quo_a, div_out.quo_b);
    grade_tri  = pick_grade(div_out.sel.src_tri,  div_out.quo_a, div_out.quo_b);
    grade_fall = pick_grade(div_out.sel.src_fall, div_out.quo_a, div_out.quo_b);
  end

  always_ff @(posedge clk) begin
    if (en[ProdStage]) begin
      prod_rise <= fgs_pkg::PROD_W'(grade_rise) * fgs_pkg::PROD_W'(weight_distant);
      prod_tri  <= fgs_pkg::PROD_W'(grade_tri)  * fgs_pkg::PROD_W'(weight_middle);
      prod_fall <= fgs_pkg::PROD_W'(grade_fall) * fgs_pkg::PROD_W'(weight_close);
      prod_err  <= div_out.sel.order_error;
    end
  end

  // Sum, rescale, saturate; force zero on order error
  always_comb begin
    sum    = fgs_pkg::SUM_W'(prod_rise) + fgs_pkg::SUM_W'(prod_tri) +
             fgs_pkg::SUM_W'(prod_fall);
    scaled = sum[fgs_pkg::SUM_W-1:F];
    if (prod_err) begin
      gain_next = '0;
    end else if (|scaled[fgs_pkg::SUM_W-F-1:fgs_pkg::GAIN_W]) begin
      gain_next = '1;
    end else begin
      gain_next = scaled[fgs_pkg::GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[OutStage]) begin
      gain        <= gain_next;
      order_error <= prod_err;
    end
  end

  assign out_valid = valid[OutStage];

endmodule

@@ design/fgs_checker.sv @@
// Port-level checker for fuzzy_gain_schedule, bound to the top level.
// Depends on fuzzy_gain_schedule_macros.svh and fgs_pkg.
`include "fuzzy_gain_schedule_macros.svh"

module fgs_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fgs_pkg::GAIN_W-1:0]    gain,
  input logic                          order_error
);

  // Misordered breakpoints always force a zero gain.
  `FGS_ASSERT_IMPL(a_err_zero_gain, clk, rst, out_valid && order_error, gain == '0, "gain not zero with order_error")

  // Input backs up only when the output side is holding a result.
  `FGS_ASSERT_IMPL(a_stall_from_out, clk, rst, in_stall, out_valid && out_stall, "input stalled while output free")

  // A held result keeps its payload.
  `FGS_ASSERT_NEXT(a_out_hold, clk, out_valid && out_stall, out_valid && $stable(gain) && $stable(order_error), rst, "stalled result changed")

  // Reset empties the pipeline and frees the input.
  `FGS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind fuzzy_gain_schedule fgs_port_checker u_fgs_checker (.*);
